[rtl/core/cse_pkg.sv]
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants of the Chebyshev series evaluator
// Word formats, queue entry, state enums and fixed-point constants.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int MAX_TERMS     = 64;
  localparam int TIME_WIDTH    = 48;                  // Q32.16
  localparam int COEFF_WIDTH   = 32;                  // Q10.22
  localparam int ACC_WIDTH     = 48;                  // Q26.22
  localparam int CHEB_WIDTH    = 32;                  // Q2.30
  localparam int CHEB_FRAC     = 30;
  localparam int IDX_WIDTH     = $clog2(MAX_TERMS + 1);
  localparam int DIV_STEPS     = CHEB_FRAC + 1;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
  localparam int PROD_WIDTH    = COEFF_WIDTH + CHEB_WIDTH;

  // 1.0 in Q2.30
  localparam logic signed [CHEB_WIDTH-1:0] CHEB_ONE = CHEB_WIDTH'(64'd1 << CHEB_FRAC);

  // input word
  typedef struct packed {
    logic                          first_term;
    logic                          last_term;
    logic signed [TIME_WIDTH-1:0]  sample_time;
    logic signed [TIME_WIDTH-1:0]  window_start;
    logic signed [TIME_WIDTH-1:0]  window_end;
    logic signed [COEFF_WIDTH-1:0] coefficient;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [COEFF_WIDTH-1:0] series_value;
    logic                          saturated;
  } out_word_t;

  // classified term, front to back
  typedef struct packed {
    logic                          first;
    logic                          last;
    logic                          degen;
    logic signed [CHEB_WIDTH-1:0]  norm;
    logic signed [COEFF_WIDTH-1:0] coefficient;
  } cse_entry_t;

  // queue status toward the front and back end
  typedef struct packed {
    logic full;
    logic empty;
  } cse_qstat_t;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_DIFF,
    FE_ABS,
    FE_CLASS,
    FE_DIV,
    FE_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_MULA,
    BK_MULB,
    BK_RND,
    BK_UPD,
    BK_OUT
  } back_state_t;

endpackage

[rtl/core/chebyshev_series_evaluator.sv]
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator: Chebyshev series evaluation in fixed point
// Sums coefficient*T(k)(u) over a series of words and returns one saturated
// result word after the word marked last.
// ----------------------------------------------------------------------------
// Flow: each term word passes through the back-end states in order (queue
// pop, two products on the single shared 32x32 multiplier, round and
// accumulate, recurrence update), and a last word adds a load of the output
// register; the next word is popped only after the update. The front end sends
// an ordinary word straight to the queue; a first word passes difference,
// magnitude and class states, then the one-bit-per-cycle divider that
// normalizes it to u, skipped when the window is degenerate or u clamps to
// -1 or 1. A 4-entry queue lets the front end normalize while the back end is
// busy, and the output register lets a new word enter while a result waits.
module chebyshev_series_evaluator import cse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic       push;
  logic       pop;
  cse_entry_t push_entry;
  cse_entry_t pop_entry;
  cse_qstat_t qstat;

  // front end: accept and normalize
  cse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .push       (push),
    .push_entry (push_entry),
    .qstat      (qstat)
  );

  // term queue
  cse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  // back end: recurrence and sum
  cse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[rtl/core/cse_front.sv]
// ----------------------------------------------------------------------------
// cse_front: input acceptance and window normalization
// Takes a word, and on a first term sets u in Q2.30 from the times by a
// one-bit-per-cycle restoring divider or a fixed code, then queues the term.
// ----------------------------------------------------------------------------
module cse_front import cse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       push,
  output cse_entry_t push_entry,
  input  cse_qstat_t qstat
);

  front_state_t state_r, state_nxt;

  in_word_t                      word_r, word_nxt;
  logic signed [TIME_WIDTH:0]    diff_n_r, diff_n_nxt;
  logic signed [TIME_WIDTH:0]    diff_d_r, diff_d_nxt;
  logic [TIME_WIDTH-1:0]         mag_n_r, mag_n_nxt;
  logic [TIME_WIDTH-1:0]         mag_d_r, mag_d_nxt;
  logic                          neg_n_r, neg_n_nxt;
  logic                          neg_d_r, neg_d_nxt;
  logic                          degen_r, degen_nxt;
  logic [TIME_WIDTH+1:0]         rem_r, rem_nxt;
  logic [CHEB_WIDTH-1:0]         q_r, q_nxt;
  logic [DIV_CNT_WIDTH-1:0]      cnt_r, cnt_nxt;

  logic                          need_div;
  logic [TIME_WIDTH:0]           neg_diff_n;
  logic [TIME_WIDTH:0]           neg_diff_d;
  logic [TIME_WIDTH+1:0]         rem_sh;
  logic                          rem_ge;

  // quotient codes for the clamped and degenerate cases (u = q - 1.0)
  localparam logic [CHEB_WIDTH-1:0] Q_MINUS_ONE = '0;
  localparam logic [CHEB_WIDTH-1:0] Q_ZERO      = CHEB_WIDTH'(64'd1 << CHEB_FRAC);
  localparam logic [CHEB_WIDTH-1:0] Q_PLUS_ONE  = CHEB_WIDTH'(64'd1 << (CHEB_FRAC + 1));

  // classification of the window
  assign need_div = (mag_d_r != '0) && (mag_n_r != '0) && (neg_n_r == neg_d_r) &&
                    (mag_n_r < mag_d_r);

  assign neg_diff_n = -diff_n_r;
  assign neg_diff_d = -diff_d_r;

  // one restoring division step
  assign rem_sh = {rem_r[TIME_WIDTH:0], 1'b0};
  assign rem_ge = rem_sh >= {2'b00, mag_d_r};

  // datapath
  always_comb begin
    word_nxt   = word_r;
    diff_n_nxt = diff_n_r;
    diff_d_nxt = diff_d_r;
    mag_n_nxt  = mag_n_r;
    mag_d_nxt  = mag_d_r;
    neg_n_nxt  = neg_n_r;
    neg_d_nxt  = neg_d_r;
    degen_nxt  = degen_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      FE_IDLE: begin
        if (in_valid) begin
          word_nxt = in_word;
        end
      end
      FE_DIFF: begin
        diff_n_nxt = (TIME_WIDTH+1)'(word_r.sample_time) -
                     (TIME_WIDTH+1)'(word_r.window_start);
        diff_d_nxt = (TIME_WIDTH+1)'(word_r.window_end) -
                     (TIME_WIDTH+1)'(word_r.window_start);
      end
      FE_ABS: begin
        neg_n_nxt = diff_n_r[TIME_WIDTH];
        neg_d_nxt = diff_d_r[TIME_WIDTH];
        mag_n_nxt = diff_n_r[TIME_WIDTH] ? neg_diff_n[TIME_WIDTH-1:0]
                                         : diff_n_r[TIME_WIDTH-1:0];
        mag_d_nxt = diff_d_r[TIME_WIDTH] ? neg_diff_d[TIME_WIDTH-1:0]
                                         : diff_d_r[TIME_WIDTH-1:0];
      end
      FE_CLASS: begin
        degen_nxt = (mag_d_r == '0);
        rem_nxt   = {2'b00, mag_n_r};
        cnt_nxt   = '0;
        if (mag_d_r == '0) begin
          q_nxt = Q_ZERO;
        end else if ((mag_n_r == '0) || (neg_n_r != neg_d_r)) begin
          q_nxt = Q_MINUS_ONE;
        end else if (mag_n_r >= mag_d_r) begin
          q_nxt = Q_PLUS_ONE;
        end else begin
          q_nxt = '0;
        end
      end
      FE_DIV: begin
        rem_nxt = rem_ge ? rem_sh - {2'b00, mag_d_r} : rem_sh;
        q_nxt   = {q_r[CHEB_WIDTH-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: begin
        if (in_valid) begin
          state_nxt = in_word.first_term ? FE_DIFF : FE_PUSH;
        end
      end
      FE_DIFF:  state_nxt = FE_ABS;
      FE_ABS:   state_nxt = FE_CLASS;
      FE_CLASS: state_nxt = need_div ? FE_DIV : FE_PUSH;
      FE_DIV: begin
        if (cnt_r == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
          state_nxt = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!qstat.full) begin
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall               = (state_r != FE_IDLE);
    push                   = (state_r == FE_PUSH) && !qstat.full;
    push_entry.first       = word_r.first_term;
    push_entry.last        = word_r.last_term;
    push_entry.degen       = degen_r;
    push_entry.norm        = $signed(q_r - CHEB_ONE);
    push_entry.coefficient = word_r.coefficient;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    word_r   <= word_nxt;
    diff_n_r <= diff_n_nxt;
    diff_d_r <= diff_d_nxt;
    mag_n_r  <= mag_n_nxt;
    mag_d_r  <= mag_d_nxt;
    neg_n_r  <= neg_n_nxt;
    neg_d_r  <= neg_d_nxt;
    degen_r  <= degen_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

[rtl/core/cse_queue.sv]
// ----------------------------------------------------------------------------
// cse_queue: term queue between front and back end
// Small register FIFO of classified terms.
// ----------------------------------------------------------------------------
module cse_queue import cse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cse_entry_t push_entry,
  input  logic       pop,
  output cse_entry_t pop_entry,
  output cse_qstat_t qstat
);

  cse_entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_WIDTH-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_WIDTH:0]   count_r, count_nxt;
  logic                  do_push;
  logic                  do_pop;

  // status
  assign qstat.full  = (count_r == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_entry   = mem_r[rd_ptr_r];

  // pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/core/cse_back.sv]
// ----------------------------------------------------------------------------
// cse_back: Chebyshev recurrence and accumulation
// Runs T(k+1) = 2u*T(k) - T(k-1) and sums coefficient*T(k) on one shared
// multiplier, and delivers the saturated sum through an output register.
// ----------------------------------------------------------------------------
module cse_back import cse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cse_qstat_t qstat,
  input  cse_entry_t pop_entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word
);

  localparam int TERM_WIDTH = PROD_WIDTH - CHEB_FRAC;
  localparam int RND_WIDTH  = PROD_WIDTH - CHEB_FRAC + 1;
  localparam int NEXT_WIDTH = RND_WIDTH + 1;

  localparam logic signed [ACC_WIDTH-1:0]   ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0]   ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [COEFF_WIDTH-1:0] OUT_MAX = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
  localparam logic signed [COEFF_WIDTH-1:0] OUT_MIN = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
  localparam logic signed [NEXT_WIDTH-1:0]  NEXT_HI = NEXT_WIDTH'(CHEB_ONE);
  localparam logic signed [NEXT_WIDTH-1:0]  NEXT_LO = -NEXT_WIDTH'(CHEB_ONE);

  // round to nearest, ties away from zero, then arithmetic shift
  function automatic logic signed [PROD_WIDTH-1:0] round_shr(
    input logic signed [PROD_WIDTH-1:0] p,
    input int                           sh
  );
    logic signed [PROD_WIDTH-1:0] bias;
    bias = (PROD_WIDTH'(1) << (sh - 1)) - PROD_WIDTH'(p[PROD_WIDTH-1]);
    return (p + bias) >>> sh;
  endfunction

  back_state_t state_r, state_nxt;

  cse_entry_t                    ent_r, ent_nxt;
  logic signed [CHEB_WIDTH-1:0]  norm_r, norm_nxt;
  logic signed [CHEB_WIDTH-1:0]  prev_r, prev_nxt;
  logic signed [CHEB_WIDTH-1:0]  curr_r, curr_nxt;
  logic signed [ACC_WIDTH-1:0]   acc_r, acc_nxt;
  logic [IDX_WIDTH-1:0]          idx_r, idx_nxt;
  logic                          degen_r, degen_nxt;
  logic                          clip_r, clip_nxt;
  logic signed [PROD_WIDTH-1:0]  prod_r, prod_nxt;
  logic signed [TERM_WIDTH-1:0]  term_r, term_nxt;
  logic signed [RND_WIDTH-1:0]   rnd_r, rnd_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_word_t                     out_word_r, out_word_nxt;

  logic signed [COEFF_WIDTH-1:0] mul_a;
  logic signed [CHEB_WIDTH-1:0]  mul_b;
  logic signed [PROD_WIDTH-1:0]  mul_p;
  logic signed [PROD_WIDTH-1:0]  rnd30;
  logic signed [PROD_WIDTH-1:0]  rnd29;
  logic signed [ACC_WIDTH:0]     sum;
  logic                          sum_ovf;
  logic signed [NEXT_WIDTH-1:0]  next_t;
  logic                          active;
  logic                          acc_on;
  logic                          out_free;
  logic                          in_range;

  // shared multiplier: coefficient*T(k), then u*T(k+1)
  assign mul_a = (state_r == BK_MULA) ? ent_r.coefficient : norm_r;
  assign mul_b = (state_r == BK_MULA) ? prev_r : curr_r;
  assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

  assign rnd30 = round_shr(prod_r, CHEB_FRAC);
  assign rnd29 = round_shr(prod_r, CHEB_FRAC - 1);

  // term gating: cap on term count, degenerate window keeps term 0 only
  assign active = (idx_r < IDX_WIDTH'(MAX_TERMS));
  assign acc_on = active && (!degen_r || (idx_r == '0));

  assign sum     = (ACC_WIDTH+1)'(acc_r) + (ACC_WIDTH+1)'(term_r);
  assign sum_ovf = (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]);
  assign next_t  = NEXT_WIDTH'(rnd_r) - NEXT_WIDTH'(prev_r);

  // result range check against the coefficient format
  assign in_range = (&acc_r[ACC_WIDTH-1:COEFF_WIDTH-1]) ||
                    (~|acc_r[ACC_WIDTH-1:COEFF_WIDTH-1]);
  assign out_free = !out_valid_r || !out_stall;

  // datapath
  always_comb begin
    ent_nxt       = ent_r;
    norm_nxt      = norm_r;
    prev_nxt      = prev_r;
    curr_nxt      = curr_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    degen_nxt     = degen_r;
    clip_nxt      = clip_r;
    prod_nxt      = prod_r;
    term_nxt      = term_r;
    rnd_nxt       = rnd_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    case (state_r)
      BK_LOAD: begin
        if (!qstat.empty) begin
          ent_nxt = pop_entry;
          if (pop_entry.first) begin
            norm_nxt  = pop_entry.norm;
            degen_nxt = pop_entry.degen;
            prev_nxt  = CHEB_ONE;
            curr_nxt  = pop_entry.norm;
            acc_nxt   = '0;
            idx_nxt   = '0;
            clip_nxt  = 1'b0;
          end
        end
      end
      BK_MULA: begin
        prod_nxt = mul_p;
      end
      BK_MULB: begin
        prod_nxt = mul_p;
        term_nxt = rnd30[TERM_WIDTH-1:0];
      end
      BK_RND: begin
        rnd_nxt = rnd29[RND_WIDTH-1:0];
        if (acc_on) begin
          if (sum_ovf) begin
            clip_nxt = 1'b1;
            acc_nxt  = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
          end else begin
            acc_nxt = sum[ACC_WIDTH-1:0];
          end
        end
      end
      BK_UPD: begin
        if (active) begin
          prev_nxt = curr_r;
          if (next_t > NEXT_HI) begin
            curr_nxt = CHEB_ONE;
          end else if (next_t < NEXT_LO) begin
            curr_nxt = -CHEB_ONE;
          end else begin
            curr_nxt = next_t[CHEB_WIDTH-1:0];
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.saturated    = clip_r || !in_range;
          out_word_nxt.series_value = in_range ? acc_r[COEFF_WIDTH-1:0]
                                    : (acc_r[ACC_WIDTH-1] ? OUT_MIN : OUT_MAX);
          // series done: restart with the stored u
          prev_nxt = CHEB_ONE;
          curr_nxt = norm_r;
          acc_nxt  = '0;
          idx_nxt  = '0;
          clip_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_LOAD: begin
        if (!qstat.empty) begin
          state_nxt = BK_MULA;
        end
      end
      BK_MULA: state_nxt = BK_MULB;
      BK_MULB: state_nxt = BK_RND;
      BK_RND:  state_nxt = BK_UPD;
      BK_UPD:  state_nxt = ent_r.last ? BK_OUT : BK_LOAD;
      BK_OUT: begin
        if (out_free) begin
          state_nxt = BK_LOAD;
        end
      end
      default: state_nxt = BK_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    pop       = (state_r == BK_LOAD) && !qstat.empty;
    out_valid = out_valid_r;
    out_word  = out_word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_LOAD;
      out_valid_r <= 1'b0;
      norm_r      <= '0;
      degen_r     <= 1'b0;
      prev_r      <= CHEB_ONE;
      curr_r      <= '0;
      acc_r       <= '0;
      idx_r       <= '0;
      clip_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      norm_r      <= norm_nxt;
      degen_r     <= degen_nxt;
      prev_r      <= prev_nxt;
      curr_r      <= curr_nxt;
      acc_r       <= acc_nxt;
      idx_r       <= idx_nxt;
      clip_r      <= clip_nxt;
    end
    ent_r      <= ent_nxt;
    prod_r     <= prod_nxt;
    term_r     <= term_nxt;
    rnd_r      <= rnd_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

[sim/chebyshev_series_evaluator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator_tb: self-checking bench for the series evaluator
// Streams series of coefficient words with bursty input and stalls on the
// result side. A fixed-point predictor computes each series sum, and every
// result word is compared field by field with the oldest predicted sum.
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator_tb;
  import cse_pkg::*;

  localparam longint UNIT    = longint'(1) << CHEB_FRAC;
  localparam longint ACC_HI  = (longint'(1) << (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_LO  = -ACC_HI - 1;
  localparam longint OUT_HI  = (longint'(1) << (COEFF_WIDTH - 1)) - 1;
  localparam longint OUT_LO  = -OUT_HI - 1;
  localparam logic signed [TIME_WIDTH-1:0] T_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
  localparam logic signed [TIME_WIDTH-1:0] T_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};
  localparam logic signed [COEFF_WIDTH-1:0] C_MAX = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
  localparam logic signed [COEFF_WIDTH-1:0] C_MIN = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
  localparam int TERM_TARGET = 1550;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  chebyshev_series_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // term words waiting to be sent; a set flag holds the word until all sums are in
  in_word_t  term_queue[$];
  bit        drain_before[$];
  out_word_t expected_sums[$];

  // predictor state
  longint      cur_u;
  longint      t_prev;
  longint      t_curr;
  longint      acc_sum;
  int unsigned term_cnt;
  bit          degen_win;
  bit          acc_sat;

  int mismatches = 0;
  int n_words = 0;
  int n_sums = 0;
  int n_sat = 0;
  int n_degen = 0;
  int n_overlong = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // a*b / 2^sh rounded to nearest, ties away from zero
  function automatic longint round_mul(longint a, longint b, int sh);
    bit neg;
    longint unsigned ma, mb, p;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    p   = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // u = 2(t-start)/(end-start) - 1 in Q2.30, clamped, exact floor division
  function automatic void normalize_time(in_word_t w);
    longint ts, ss, es, mag_n, mag_d;
    bit neg_n, neg_d;
    logic [95:0] num;
    ts = w.sample_time;
    ss = w.window_start;
    es = w.window_end;
    neg_n = ts < ss;
    neg_d = es < ss;
    mag_n = neg_n ? ss - ts : ts - ss;
    mag_d = neg_d ? ss - es : es - ss;
    degen_win = (mag_d == 0);
    if (degen_win) begin
      cur_u = 0;
    end else if (mag_n == 0 || neg_n != neg_d) begin
      cur_u = -UNIT;
    end else if (mag_n >= mag_d) begin
      cur_u = UNIT;
    end else begin
      num   = 96'(mag_n) << 31;
      cur_u = longint'(num / 96'(mag_d)) - UNIT;
    end
  endfunction

  function automatic void restart_series();
    t_prev   = UNIT;
    t_curr   = cur_u;
    acc_sum  = 0;
    term_cnt = 0;
    acc_sat  = 1'b0;
  endfunction

  // advance the series by one accepted word, queue the sum on the last one
  function automatic void predict_term(in_word_t w);
    longint coeff, total, nxt;
    out_word_t r;
    coeff = w.coefficient;
    if (w.first_term) begin
      normalize_time(w);
      restart_series();
      if (degen_win) n_degen++;
    end
    if (term_cnt < MAX_TERMS) begin
      if (!degen_win || term_cnt == 0) begin
        total = acc_sum + round_mul(coeff, t_prev, CHEB_FRAC);
        if (total > ACC_HI || total < ACC_LO) acc_sat = 1'b1;
        acc_sum = clip(total, ACC_LO, ACC_HI);
      end
      nxt      = round_mul(cur_u, t_curr, CHEB_FRAC - 1) - t_prev;
      t_prev   = t_curr;
      t_curr   = clip(nxt, -UNIT, UNIT);
      term_cnt = term_cnt + 1;
    end else begin
      n_overlong++;
    end
    if (w.last_term) begin
      r.saturated    = acc_sat || acc_sum > OUT_HI || acc_sum < OUT_LO;
      r.series_value = COEFF_WIDTH'(clip(acc_sum, OUT_LO, OUT_HI));
      expected_sums = {expected_sums, r};
      restart_series();
    end
  endfunction

  function automatic void check_sum(out_word_t got);
    out_word_t want;
    if (expected_sums.size() == 0) begin
      $error("series_value: no sum expected, got %0d", got.series_value);
      mismatches++;
      return;
    end
    want = expected_sums.pop_front();
    n_sums++;
    if (want.saturated) n_sat++;
    if (got.series_value !== want.series_value) begin
      $error("series_value: expected %0d, got %0d", want.series_value, got.series_value);
      mismatches++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
      mismatches++;
    end
  endfunction

  function automatic logic signed [TIME_WIDTH-1:0] rand_time();
    return TIME_WIDTH'({$urandom(), $urandom()});
  endfunction

  function automatic void add_word(bit first, bit last, logic signed [TIME_WIDTH-1:0] t,
                                   logic signed [TIME_WIDTH-1:0] s,
                                   logic signed [TIME_WIDTH-1:0] e,
                                   logic signed [COEFF_WIDTH-1:0] c, bit drain);
    in_word_t w;
    w.first_term   = first;
    w.last_term    = last;
    w.sample_time  = t;
    w.window_start = s;
    w.window_end   = e;
    w.coefficient  = c;
    term_queue   = {term_queue, w};
    drain_before = {drain_before, drain};
  endfunction

  function automatic logic signed [COEFF_WIDTH-1:0] rand_coeff(int kind);
    case (kind)
      0:       return $urandom();
      1:       return COEFF_WIDTH'(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
      default: begin
        case ($urandom_range(0, 4))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          3:       return 1;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // one series with random window, length and content; sometimes malformed
  function automatic void add_random_series(bit drain);
    longint s, e, t, span;
    int len, wmode, cmode, pick;
    bit no_first, no_last;
    span = ((longint'($urandom()) << 14) | $urandom_range(0, 16383)) >> $urandom_range(0, 40);
    if (span == 0) span = 1;
    s = longint'(rand_time()) >>> 2;
    pick = $urandom_range(0, 99);
    wmode = (pick < 15) ? 0 : (pick < 70) ? 1 : (pick < 80) ? 2 :
            (pick < 90) ? 3 : (pick < 95) ? 4 : 5;
    case (wmode)
      0: begin
        s = rand_time();
        e = rand_time();
        t = rand_time();
      end
      1: begin
        e = s + span;
        t = s - span / 4 + (span * 3 / 2) * $urandom_range(0, 1023) / 1024;
      end
      2: begin
        e = s;
        t = rand_time();
      end
      3: begin
        e = s - span;
        t = e - span / 4 + (span * 3 / 2) * $urandom_range(0, 1023) / 1024;
      end
      4: begin
        e = rand_time();
        t = s;
      end
      default: begin
        e = s + span;
        t = ($urandom_range(0, 1) != 0) ? longint'(T_MAX) : e + $urandom_range(0, 1000);
      end
    endcase
    pick = $urandom_range(0, 99);
    len  = (pick < 85) ? $urandom_range(1, 8) : (pick < 95) ? $urandom_range(9, 30)
                                                            : $urandom_range(60, 80);
    pick  = $urandom_range(0, 99);
    cmode = (pick < 45) ? 0 : (pick < 90) ? 1 : 2;
    no_first = ($urandom_range(0, 11) == 0);
    no_last  = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < len; k++) begin
      if (k == 0)
        add_word(!no_first, (len == 1) && !no_last, TIME_WIDTH'(t), TIME_WIDTH'(s),
                 TIME_WIDTH'(e), rand_coeff(cmode), drain);
      else
        add_word(1'b0, (k == len - 1) && !no_last, rand_time(), rand_time(), rand_time(),
                 rand_coeff(cmode), 1'b0);
    end
  endfunction

  // stimulus and end of run
  initial begin
    int series_no;
    logic signed [TIME_WIDTH-1:0] q16;
    q16 = TIME_WIDTH'(longint'(1) << 16);

    // no first marker after reset: u = 0 with a valid window
    add_word(1'b0, 1'b0, rand_time(), rand_time(), rand_time(), C_MAX, 1'b0);
    add_word(1'b0, 1'b1, rand_time(), rand_time(), rand_time(), C_MIN, 1'b0);
    // one-term series, sample time equal to window start
    add_word(1'b1, 1'b1, '0, '0, 1, C_MIN, 1'b0);
    // degenerate window: only the first coefficient counts
    add_word(1'b1, 1'b0, T_MAX, 123 * q16, 123 * q16, 32'sh0040_0000, 1'b0);
    add_word(1'b0, 1'b0, T_MIN, T_MIN, T_MAX, C_MAX, 1'b0);
    add_word(1'b0, 1'b1, rand_time(), rand_time(), rand_time(), 32'sh1234_5678, 1'b0);
    // time past the window end, u = 1: positive saturation
    add_word(1'b1, 1'b0, T_MAX, T_MIN, '0, C_MAX, 1'b0);
    add_word(1'b0, 1'b0, rand_time(), rand_time(), rand_time(), C_MAX, 1'b0);
    add_word(1'b0, 1'b1, rand_time(), rand_time(), rand_time(), C_MAX, 1'b0);
    // reversed window, time in the middle
    add_word(1'b1, 1'b0, '0, 1000 * q16, -1000 * q16, 32'sh0123_4567, 1'b1);
    add_word(1'b0, 1'b1, '0, '0, '0, -32'sh0234_5678, 1'b0);
    // time before window start, u = -1: T(k) alternates in sign
    add_word(1'b1, 1'b0, T_MIN, -5 * q16, 5 * q16, C_MIN, 1'b0);
    add_word(1'b0, 1'b0, T_MAX, T_MAX, T_MAX, C_MIN, 1'b0);
    add_word(1'b0, 1'b1, '0, '0, '0, C_MIN, 1'b0);
    // full-range window, interior time
    add_word(1'b1, 1'b0, rand_time(), T_MIN, T_MAX, $urandom(), 1'b0);
    add_word(1'b0, 1'b0, rand_time(), rand_time(), rand_time(), $urandom(), 1'b0);
    add_word(1'b0, 1'b0, rand_time(), rand_time(), rand_time(), $urandom(), 1'b0);
    add_word(1'b0, 1'b1, rand_time(), rand_time(), rand_time(), $urandom(), 1'b0);

    series_no = 0;
    while (term_queue.size() < TERM_TARGET) begin
      add_random_series(series_no % 40 == 0);
      series_no++;
    end
    // close whatever series is still open
    add_word(1'b0, 1'b1, rand_time(), rand_time(), rand_time(), $urandom(), 1'b0);

    cur_u     = 0;
    degen_win = 1'b0;
    restart_series();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (term_queue.size() != 0 || in_valid) @(negedge clk);
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Sent %0d words; checked %0d sums, %0d of them saturated.", n_words, n_sums,
             n_sat);
    $display("Degenerate windows: %0d; words past the term limit: %0d.", n_degen,
             n_overlong);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // input driver: bursts with random gaps, optional drain pause per word
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_term(in_word);
        n_words++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (term_queue.size() != 0 &&
                   !(drain_before[0] && expected_sums.size() != 0)) begin
        in_word  <= term_queue.pop_front();
        void'(drain_before.pop_front());
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and stall pattern
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_sum(out_word);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

endmodule

[sim.f]
rtl/core/cse_pkg.sv
rtl/core/cse_front.sv
rtl/core/cse_queue.sv
rtl/core/cse_back.sv
rtl/core/chebyshev_series_evaluator.sv
sim/chebyshev_series_evaluator_tb.sv
